// File: hdl/bas_pkg.sv
// ---------------------------------------------------------------------------
// bas_pkg: shared types and constants for the bounded A* search block
// Field widths, operation and result codes, register indexes, and the
// command/status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package bas_pkg;

   // field widths
   localparam int NODE_W     = 3;
   localparam int WEIGHT_W   = 8;
   localparam int HEUR_W     = 8;
   localparam int COST_W     = 16;
   localparam int KIND_W     = 2;
   localparam int OP_W       = 2;
   localparam int MAXEXP_W   = 5;
   localparam int NCOUNT_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // parameter defaults
   localparam int NODES_DEF          = 8;
   localparam int EDGES_PER_NODE_DEF = 16;
   localparam int OPEN_DEPTH_DEF     = 256;
   localparam int PATH_MAX_DEF       = 17;

   // expansion bookkeeping: one path record per counted expansion
   localparam int EXP_CAP = 16;
   localparam int EXP_W   = 5;
   localparam int REC_W   = 4;
   localparam logic [EXP_W-1:0] EXP_LIMIT = 5'd16;
   localparam logic [EXP_W-1:0] ROOT_PAR  = 5'd16;

   // register reset values
   localparam logic [NODE_W-1:0]   START_RST  = 3'd0;
   localparam logic [NODE_W-1:0]   GOAL_RST   = 3'd6;
   localparam logic [MAXEXP_W-1:0] MAXEXP_RST = 5'd9;
   localparam logic [NCOUNT_W-1:0] NCOUNT_RST = 4'd7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAXEXP = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NCOUNT = 2'd3;

   // operations
   localparam logic [OP_W-1:0] OP_SET_HEUR = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN      = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_EXPAND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PATH   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FAIL   = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic [WEIGHT_W-1:0] weight;
      logic [HEUR_W-1:0]   heuristic;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NODE_W-1:0] node;
      logic [COST_W-1:0] total_cost;
      logic              last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic add_back;
      logic run_init;
      logic scan_start;
      logic open_rd;
      logic scan_step;
      logic tie_start;
      logic tie_rd;
      logic tie_end;
      logic j_inc;
      logic rm_rd;
      logic rm_wr;
      logic expand;
      logic rec_rd;
      logic copy_wr;
      logic copy_tail;
      logic exp_inc;
      logic adj_rd;
      logic k_inc;
      logic nb_build;
      logic idx_inc;
      logic insert;
      logic emit_fail;
      logic emit_tail;
      logic emit_path;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic stop;
      logic key_tie;
      logic scan_last;
      logic tie_done;
      logic pop_skip;
      logic pop_goal;
      logic j_tail;
      logic nb_done;
      logic nb_skip;
      logic dup_end;
      logic dup_hit;
   } stat_type;

endpackage

// File: hdl/bounded_a_star_search.sv
// ---------------------------------------------------------------------------
// bounded_a_star_search: A* search over a small weighted graph
// Loads heuristics and undirected edges, then searches from start_node
// to goal_node with a bounded number of expansions.
// ---------------------------------------------------------------------------
// Usage:
//   A command word is taken when start is high and busy is low. Set
//   heuristic and clear graph return straight to idle; add edge writes
//   one list on acceptance and the other in a second load state. A run
//   walks the open set: each pop scans every open entry for the minimum,
//   comparing paths element by element on an exact f/g/node tie; each
//   non-goal expansion copies the inherited path and adds its node; each
//   in-range neighbor is scanned for in the open set and inserted if not found.
//   Results appear on rsp_data for exactly one cycle with rsp_valid high:
//   one word per expansion, then either the goal path (last set on its
//   final node) or one not-found word with last set. The receiver cannot
//   stall. Registers are written through csr_we/csr_index/csr_wdata by
//   the user only while busy is low; the block does not enforce this.
//   Reset restores register defaults, zero heuristics and empty
//   adjacency lists; no memory clearing pass is needed.
// ---------------------------------------------------------------------------
module bounded_a_star_search #(
   parameter int NODES          = bas_pkg::NODES_DEF,
   parameter int EDGES_PER_NODE = bas_pkg::EDGES_PER_NODE_DEF,
   parameter int OPEN_DEPTH     = bas_pkg::OPEN_DEPTH_DEF,
   parameter int PATH_MAX       = bas_pkg::PATH_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  bas_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output bas_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [bas_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bas_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bas_pkg::cmd_type  cmd;
   bas_pkg::stat_type stat;

   bas_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.operation),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   bas_datapath #(
      .NODES          (NODES),
      .EDGES_PER_NODE (EDGES_PER_NODE),
      .OPEN_DEPTH     (OPEN_DEPTH),
      .PATH_MAX       (PATH_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/bas_ctrl.sv
// ---------------------------------------------------------------------------
// bas_ctrl: search sequencer
// Walks loads, open set scans, path copies, neighbor pushes and result
// emission by issuing commands to the datapath and reading its status.
// ---------------------------------------------------------------------------
module bas_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bas_pkg::OP_W-1:0]  req_op,
   input  bas_pkg::stat_type         stat,
   output bas_pkg::cmd_type          cmd,
   output logic                      busy
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_LOAD_B   = 5'd1;
   localparam logic [4:0] S_RUN_INIT = 5'd2;
   localparam logic [4:0] S_POP_CHK  = 5'd3;
   localparam logic [4:0] S_SCAN_RD  = 5'd4;
   localparam logic [4:0] S_SCAN_EV  = 5'd5;
   localparam logic [4:0] S_TIE_RD   = 5'd6;
   localparam logic [4:0] S_TIE_EV   = 5'd7;
   localparam logic [4:0] S_RM_RD    = 5'd8;
   localparam logic [4:0] S_RM_WR    = 5'd9;
   localparam logic [4:0] S_EXPAND   = 5'd10;
   localparam logic [4:0] S_COPY_RD  = 5'd11;
   localparam logic [4:0] S_COPY_WR  = 5'd12;
   localparam logic [4:0] S_NB_CHK   = 5'd13;
   localparam logic [4:0] S_NB_EV    = 5'd14;
   localparam logic [4:0] S_DUP_CHK  = 5'd15;
   localparam logic [4:0] S_DUP_EV   = 5'd16;
   localparam logic [4:0] S_INSERT   = 5'd17;
   localparam logic [4:0] S_PATH_RD  = 5'd18;
   localparam logic [4:0] S_PATH_EV  = 5'd19;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   assign busy = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               case (req_op)
                  bas_pkg::OP_ADD_EDGE: state_in = S_LOAD_B;
                  bas_pkg::OP_RUN:      state_in = S_RUN_INIT;
                  default:              state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD_B: begin
            cmd.add_back = 1'b1;
            state_in     = S_IDLE;
         end
         S_RUN_INIT: begin
            cmd.run_init = 1'b1;
            state_in     = S_POP_CHK;
         end
         S_POP_CHK: begin
            if (stat.stop) begin
               cmd.emit_fail = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.open_rd = 1'b1;
            state_in    = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            if (stat.key_tie) begin
               cmd.tie_start = 1'b1;
               state_in      = S_TIE_RD;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = stat.scan_last ? S_RM_RD : S_SCAN_RD;
            end
         end
         S_TIE_RD: begin
            cmd.tie_rd = 1'b1;
            state_in   = S_TIE_EV;
         end
         S_TIE_EV: begin
            if (stat.tie_done) begin
               cmd.tie_end = 1'b1;
               state_in    = stat.scan_last ? S_RM_RD : S_SCAN_RD;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = S_TIE_RD;
            end
         end
         S_RM_RD: begin
            cmd.rm_rd = 1'b1;
            state_in  = S_RM_WR;
         end
         S_RM_WR: begin
            cmd.rm_wr = 1'b1;
            state_in  = S_EXPAND;
         end
         S_EXPAND: begin
            if (stat.pop_skip) begin
               state_in = S_POP_CHK;
            end else begin
               cmd.expand = 1'b1;
               state_in   = stat.pop_goal ? S_PATH_RD : S_COPY_RD;
            end
         end
         S_COPY_RD: begin
            if (stat.j_tail) begin
               cmd.copy_tail = 1'b1;
               state_in      = S_NB_CHK;
            end else begin
               cmd.rec_rd = 1'b1;
               state_in   = S_COPY_WR;
            end
         end
         S_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            cmd.j_inc   = 1'b1;
            state_in    = S_COPY_RD;
         end
         S_NB_CHK: begin
            if (stat.nb_done) begin
               cmd.exp_inc = 1'b1;
               state_in    = S_POP_CHK;
            end else begin
               cmd.adj_rd = 1'b1;
               state_in   = S_NB_EV;
            end
         end
         S_NB_EV: begin
            if (stat.nb_skip) begin
               cmd.k_inc = 1'b1;
               state_in  = S_NB_CHK;
            end else begin
               cmd.nb_build = 1'b1;
               state_in     = S_DUP_CHK;
            end
         end
         S_DUP_CHK: begin
            if (stat.dup_end) begin
               state_in = S_INSERT;
            end else begin
               cmd.open_rd = 1'b1;
               state_in    = S_DUP_EV;
            end
         end
         S_DUP_EV: begin
            if (stat.dup_hit) begin
               cmd.k_inc = 1'b1;
               state_in  = S_NB_CHK;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_DUP_CHK;
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_NB_CHK;
         end
         S_PATH_RD: begin
            if (stat.j_tail) begin
               cmd.emit_tail = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.rec_rd = 1'b1;
               state_in   = S_PATH_EV;
            end
         end
         S_PATH_EV: begin
            cmd.emit_path = 1'b1;
            cmd.j_inc     = 1'b1;
            state_in      = S_PATH_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/bas_datapath.sv
// ---------------------------------------------------------------------------
// bas_datapath: graph store, open set and path records
// Holds configuration, heuristics, adjacency lists, the open set memory,
// per-expansion path records and the result register.
// ---------------------------------------------------------------------------
module bas_datapath #(
   parameter int NODES          = bas_pkg::NODES_DEF,
   parameter int EDGES_PER_NODE = bas_pkg::EDGES_PER_NODE_DEF,
   parameter int OPEN_DEPTH     = bas_pkg::OPEN_DEPTH_DEF,
   parameter int PATH_MAX       = bas_pkg::PATH_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bas_pkg::req_type                 req_data,
   input  logic                             csr_we,
   input  logic [bas_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bas_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  bas_pkg::cmd_type                 cmd,
   output bas_pkg::stat_type                stat,
   output logic                             rsp_valid,
   output bas_pkg::rsp_type                 rsp_data
);

   localparam int NN        = 2 ** bas_pkg::NODE_W;
   localparam int KW        = (EDGES_PER_NODE > 1) ? $clog2(EDGES_PER_NODE) : 1;
   localparam int CW        = $clog2(EDGES_PER_NODE + 1);
   localparam int AW        = $clog2(OPEN_DEPTH);
   localparam int CNTW      = $clog2(OPEN_DEPTH + 1);
   localparam int PW        = $clog2(PATH_MAX);
   localparam int LW        = $clog2(PATH_MAX + 1);
   localparam int ADJ_DEPTH = 1 << (bas_pkg::NODE_W + KW);
   localparam int REC_DEPTH = bas_pkg::EXP_CAP << PW;
   localparam int REC_W_L   = bas_pkg::REC_W + PW;

   typedef struct packed {
      logic [bas_pkg::COST_W-1:0] f;
      logic [bas_pkg::COST_W-1:0] g;
      logic [bas_pkg::NODE_W-1:0] node;
      logic [LW-1:0]              len;
      logic [bas_pkg::EXP_W-1:0]  par;
   } entry_type;

   typedef struct packed {
      logic [bas_pkg::NODE_W-1:0]   node;
      logic [bas_pkg::WEIGHT_W-1:0] weight;
   } adj_type;

   // configuration
   logic [bas_pkg::NODE_W-1:0]   start_ff;
   logic [bas_pkg::NODE_W-1:0]   goal_ff;
   logic [bas_pkg::MAXEXP_W-1:0] maxexp_ff;
   logic [bas_pkg::NCOUNT_W-1:0] ncount_ff;

   // graph state
   bas_pkg::req_type             req_ff;
   logic [bas_pkg::HEUR_W-1:0]   heur_ff [NN];
   logic [CW-1:0]                cnt_ff  [NN];
   logic [NN-1:0]                visited_ff;
   adj_type                      adj_mem [ADJ_DEPTH];
   adj_type                      adj_q_ff;

   // open set and path records
   entry_type                    open_mem [OPEN_DEPTH];
   entry_type                    open_q_ff;
   logic [bas_pkg::NODE_W-1:0]   rec_mem [REC_DEPTH];
   logic [bas_pkg::NODE_W-1:0]   rec_qa_ff;
   logic [bas_pkg::NODE_W-1:0]   rec_qb_ff;

   // search registers
   logic [CNTW-1:0]              count_ff;
   logic [CNTW-1:0]              idx_ff;
   entry_type                    best_ff;
   logic [AW-1:0]                best_idx_ff;
   entry_type                    new_ff;
   logic [LW-1:0]                j_ff;
   logic [CW-1:0]                k_ff;
   logic [bas_pkg::EXP_W-1:0]    exp_ff;
   logic                         rsp_valid_ff;
   bas_pkg::rsp_type             rsp_data_ff;

   // combinational
   logic                         add_en;
   logic [bas_pkg::NODE_W-1:0]   add_from;
   logic [bas_pkg::NODE_W-1:0]   add_to;
   logic [bas_pkg::WEIGHT_W-1:0] add_w;
   logic [bas_pkg::NODE_W-1:0]   cnt_addr;
   logic [CW-1:0]                cur_cnt;
   logic [bas_pkg::NODE_W-1:0]   h_addr;
   logic [bas_pkg::HEUR_W-1:0]   h_val;
   logic                         key_less;
   logic                         key_eq;
   logic [LW-1:0]                len_min;
   logic [bas_pkg::NODE_W-1:0]   elem_a;
   logic [bas_pkg::NODE_W-1:0]   elem_b;
   logic                         at_min;
   logic                         tie_less;
   logic                         take;
   entry_type                    nb_entry;
   logic [bas_pkg::COST_W-1:0]   nb_g;
   logic                         open_we;
   logic [AW-1:0]                open_waddr;
   entry_type                    open_wdata;
   logic [AW-1:0]                open_raddr;
   logic [REC_W_L-1:0]           rec_ra;
   logic [REC_W_L-1:0]           rec_rb;
   logic [REC_W_L-1:0]           rec_wa;

   function automatic logic node_used(input logic [bas_pkg::NODE_W-1:0] x,
                                      input logic [bas_pkg::NCOUNT_W-1:0] nc);
      node_used = (bas_pkg::NCOUNT_W'(x) < nc) && (32'(x) < NODES);
   endfunction

   // edge half selection: first half from the request, second from the copy
   assign add_en   = cmd.add_back ||
                     (cmd.accept && req_data.operation == bas_pkg::OP_ADD_EDGE);
   assign add_from = cmd.add_back ? req_ff.node_b : req_data.node_a;
   assign add_to   = cmd.add_back ? req_ff.node_a : req_data.node_b;
   assign add_w    = cmd.add_back ? req_ff.weight : req_data.weight;

   // single read site for the adjacency counts and heuristics
   assign cnt_addr = add_en ? add_from : best_ff.node;
   assign cur_cnt  = cnt_ff[cnt_addr];
   assign h_addr   = cmd.run_init ? start_ff : adj_q_ff.node;
   assign h_val    = heur_ff[h_addr];

   // open set ordering on f, g, node
   assign key_eq   = (open_q_ff.f == best_ff.f) && (open_q_ff.g == best_ff.g) &&
                     (open_q_ff.node == best_ff.node);
   assign key_less = (open_q_ff.f < best_ff.f) ||
                     ((open_q_ff.f == best_ff.f) &&
                      ((open_q_ff.g < best_ff.g) ||
                       ((open_q_ff.g == best_ff.g) && (open_q_ff.node < best_ff.node))));
   assign take     = (idx_ff == '0) || key_less;

   // path tie break, one element per step
   assign len_min  = (best_ff.len < open_q_ff.len) ? best_ff.len : open_q_ff.len;
   assign elem_a   = (j_ff == best_ff.len - 1'b1) ? best_ff.node : rec_qa_ff;
   assign elem_b   = (j_ff == open_q_ff.len - 1'b1) ? open_q_ff.node : rec_qb_ff;
   assign at_min   = (j_ff == len_min);
   assign tie_less = at_min ? (open_q_ff.len < best_ff.len) : (elem_b < elem_a);

   // neighbor entry
   assign nb_g          = best_ff.g + bas_pkg::COST_W'(adj_q_ff.weight);
   assign nb_entry.g    = nb_g;
   assign nb_entry.f    = nb_g + bas_pkg::COST_W'(h_val);
   assign nb_entry.node = adj_q_ff.node;
   assign nb_entry.len  = LW'(best_ff.len + 1'b1);
   assign nb_entry.par  = exp_ff;

   // status
   assign stat.stop      = (count_ff == '0) || (exp_ff >= maxexp_ff) ||
                           (exp_ff >= bas_pkg::EXP_LIMIT);
   assign stat.key_tie   = (idx_ff != '0) && key_eq;
   assign stat.scan_last = (idx_ff == count_ff - 1'b1);
   assign stat.tie_done  = at_min || (elem_a != elem_b);
   assign stat.pop_skip  = !(32'(best_ff.node) < NODES) || visited_ff[best_ff.node];
   assign stat.pop_goal  = (best_ff.node == goal_ff);
   assign stat.j_tail    = (j_ff == best_ff.len - 1'b1);
   assign stat.nb_done   = (k_ff >= cur_cnt) || (32'(k_ff) >= EDGES_PER_NODE);
   assign stat.nb_skip   = !node_used(adj_q_ff.node, ncount_ff) ||
                           (32'(best_ff.len) >= PATH_MAX);
   assign stat.dup_end   = (idx_ff == count_ff);
   assign stat.dup_hit   = (open_q_ff == new_ff);

   // open set write and read port selection
   always_comb begin
      open_we    = 1'b0;
      open_waddr = best_idx_ff;
      open_wdata = open_q_ff;
      if (cmd.run_init) begin
         open_we         = node_used(start_ff, ncount_ff);
         open_waddr      = '0;
         open_wdata.f    = bas_pkg::COST_W'(h_val);
         open_wdata.g    = '0;
         open_wdata.node = start_ff;
         open_wdata.len  = LW'(1);
         open_wdata.par  = bas_pkg::ROOT_PAR;
      end else if (cmd.rm_wr) begin
         open_we = 1'b1;
      end else if (cmd.insert) begin
         open_we    = (32'(count_ff) < OPEN_DEPTH);
         open_waddr = count_ff[AW-1:0];
         open_wdata = new_ff;
      end
   end

   assign open_raddr = cmd.rm_rd ? AW'(count_ff - 1'b1) : idx_ff[AW-1:0];
   assign rec_ra     = {best_ff.par[bas_pkg::REC_W-1:0], j_ff[PW-1:0]};
   assign rec_rb     = {open_q_ff.par[bas_pkg::REC_W-1:0], j_ff[PW-1:0]};
   assign rec_wa     = {exp_ff[bas_pkg::REC_W-1:0], j_ff[PW-1:0]};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= bas_pkg::START_RST;
         goal_ff   <= bas_pkg::GOAL_RST;
         maxexp_ff <= bas_pkg::MAXEXP_RST;
         ncount_ff <= bas_pkg::NCOUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            bas_pkg::CSR_START:  start_ff  <= csr_wdata[bas_pkg::NODE_W-1:0];
            bas_pkg::CSR_GOAL:   goal_ff   <= csr_wdata[bas_pkg::NODE_W-1:0];
            bas_pkg::CSR_MAXEXP: maxexp_ff <= csr_wdata[bas_pkg::MAXEXP_W-1:0];
            bas_pkg::CSR_NCOUNT: ncount_ff <= csr_wdata[bas_pkg::NCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // heuristics, adjacency counts, visited flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NN; i++) begin
            heur_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         visited_ff <= '0;
      end else begin
         if (cmd.accept && req_data.operation == bas_pkg::OP_SET_HEUR) begin
            heur_ff[req_data.node_a] <= req_data.heuristic;
         end
         if (cmd.accept && req_data.operation == bas_pkg::OP_CLEAR) begin
            for (int i = 0; i < NN; i++) begin
               cnt_ff[i] <= '0;
            end
         end else if (add_en && (32'(cur_cnt) < EDGES_PER_NODE)) begin
            cnt_ff[add_from] <= CW'(cur_cnt + 1'b1);
         end
         if (cmd.run_init) begin
            visited_ff <= '0;
         end else if (cmd.expand) begin
            visited_ff[best_ff.node] <= 1'b1;
         end
      end
   end

   // request copy for the back half of an edge load
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
   end

   // adjacency memory
   always_ff @(posedge clock) begin
      if (add_en && (32'(cur_cnt) < EDGES_PER_NODE)) begin
         adj_mem[{add_from, cur_cnt[KW-1:0]}] <= '{node: add_to, weight: add_w};
      end
      if (cmd.adj_rd) begin
         adj_q_ff <= adj_mem[{best_ff.node, k_ff[KW-1:0]}];
      end
   end

   // open set memory
   always_ff @(posedge clock) begin
      if (open_we) begin
         open_mem[open_waddr] <= open_wdata;
      end
      if (cmd.open_rd || cmd.rm_rd) begin
         open_q_ff <= open_mem[open_raddr];
      end
   end

   // path record memory
   always_ff @(posedge clock) begin
      if (cmd.copy_wr) begin
         rec_mem[rec_wa] <= rec_qa_ff;
      end else if (cmd.copy_tail) begin
         rec_mem[rec_wa] <= best_ff.node;
      end
      if (cmd.rec_rd || cmd.tie_rd) begin
         rec_qa_ff <= rec_mem[rec_ra];
      end
      if (cmd.tie_rd) begin
         rec_qb_ff <= rec_mem[rec_rb];
      end
   end

   // search control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         exp_ff   <= '0;
      end else begin
         if (cmd.run_init) begin
            count_ff <= node_used(start_ff, ncount_ff) ? CNTW'(1) : '0;
            exp_ff   <= '0;
         end else if (cmd.rm_wr) begin
            count_ff <= count_ff - 1'b1;
         end else if (cmd.insert && (32'(count_ff) < OPEN_DEPTH)) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.exp_inc) begin
            exp_ff <= exp_ff + 1'b1;
         end
         if (cmd.scan_start || cmd.nb_build) begin
            idx_ff <= '0;
         end else if (cmd.scan_step || cmd.tie_end || cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.tie_start || cmd.expand) begin
            j_ff <= '0;
         end else if (cmd.j_inc) begin
            j_ff <= j_ff + 1'b1;
         end
         if (cmd.copy_tail) begin
            k_ff <= '0;
         end else if (cmd.k_inc || cmd.insert) begin
            k_ff <= k_ff + 1'b1;
         end
      end
   end

   // best entry and candidate neighbor
   always_ff @(posedge clock) begin
      if ((cmd.scan_step && take) || (cmd.tie_end && tie_less)) begin
         best_ff     <= open_q_ff;
         best_idx_ff <= idx_ff[AW-1:0];
      end
      if (cmd.nb_build) begin
         new_ff <= nb_entry;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.expand || cmd.emit_fail || cmd.emit_tail || cmd.emit_path;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.expand) begin
         rsp_data_ff <= '{kind: bas_pkg::KIND_EXPAND, node: best_ff.node,
                          total_cost: best_ff.f, last: 1'b0};
      end else if (cmd.emit_tail) begin
         rsp_data_ff <= '{kind: bas_pkg::KIND_PATH, node: best_ff.node,
                          total_cost: '0, last: 1'b1};
      end else if (cmd.emit_path) begin
         rsp_data_ff <= '{kind: bas_pkg::KIND_PATH, node: rec_qa_ff,
                          total_cost: '0, last: 1'b0};
      end else if (cmd.emit_fail) begin
         rsp_data_ff <= '{kind: bas_pkg::KIND_FAIL, node: '0,
                          total_cost: '0, last: 1'b1};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hdl/bas_checker.sv
// ---------------------------------------------------------------------------
// bas_checker: port-level checks for the A* search block
// Watches commands and result words on the top-level ports.
// ---------------------------------------------------------------------------
module bas_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input bas_pkg::req_type  req_data,
   input logic              rsp_valid,
   input bas_pkg::rsp_type  rsp_data
);

   // the final word of a run is never followed at once by another
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result word right after final word");

   // not-found always closes the run with cleared fields
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == bas_pkg::KIND_FAIL |->
         rsp_data.last && rsp_data.node == '0 && rsp_data.total_cost == '0)
      else $error("bad not-found word");

   // an expansion word never ends a run
   a_expand_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == bas_pkg::KIND_EXPAND |-> !rsp_data.last)
      else $error("expansion word marked last");

   // a run command holds the block busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.operation == bas_pkg::OP_RUN |=> busy)
      else $error("run accepted but block idle");

   // heuristic and clear loads leave the block free
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.operation == bas_pkg::OP_SET_HEUR ||
                         req_data.operation == bas_pkg::OP_CLEAR) |=> !busy)
      else $error("load left block busy");

endmodule

bind bounded_a_star_search bas_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
